FILE: rtl/core/text_console_cursor_scroll_defines.svh
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_defines
// Assertion macros shared by the console controller RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// same-cycle implication on clk, masked during reset
`define TCCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, masked during reset
`define TCCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Types and constants of the text console cursor and scroll controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccs_pkg;

  localparam int ADDR_W = 14;
  localparam int CHAR_W = 8;
  localparam int TYPE_W = 2;
  localparam int CON_W  = 2;

  localparam int DEF_CONSOLES     = 3;
  localparam int DEF_ROW_CELLS    = 80;
  localparam int DEF_SCREEN_CELLS = 2000;
  localparam int DEF_VMEM_WORDS   = 16384;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ATTR = 1'b0;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h07;

  typedef enum logic [TYPE_W-1:0] {
    REQ_CHAR        = 2'd0,
    REQ_SELECT      = 2'd1,
    REQ_SCROLL_UP   = 2'd2,
    REQ_SCROLL_DOWN = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [CON_W-1:0]  console_index;
    logic [CHAR_W-1:0] char_code;
  } req_t;

  typedef struct packed {
    logic              vram_write;
    logic [ADDR_W-1:0] vram_addr;
    logic [CHAR_W-1:0] vram_char;
    logic [CHAR_W-1:0] vram_attr;
    logic              display_update;
    logic [ADDR_W-1:0] display_start;
    logic [ADDR_W-1:0] display_cursor;
  } res_t;

endpackage

FILE: rtl/core/tccs_if.sv
// ----------------------------------------------------------------------------
// tccs_if
// Valid/ready channels for console requests and console results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tccs_req_if import tccs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [CON_W-1:0]  console_index;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output req_type, output console_index,
                  output char_code, input ready);
  modport sink   (input valid, input req_type, input console_index,
                  input char_code, output ready);
endinterface

interface tccs_res_if import tccs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              vram_write;
  logic [ADDR_W-1:0] vram_addr;
  logic [CHAR_W-1:0] vram_char;
  logic [CHAR_W-1:0] vram_attr;
  logic              display_update;
  logic [ADDR_W-1:0] display_start;
  logic [ADDR_W-1:0] display_cursor;

  modport source (output valid, output vram_write, output vram_addr,
                  output vram_char, output vram_attr, output display_update,
                  output display_start, output display_cursor, input ready);
  modport sink   (input valid, input vram_write, input vram_addr,
                  input vram_char, input vram_attr, input display_update,
                  input display_start, input display_cursor, output ready);
endinterface

FILE: rtl/core/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Pipeline: the request loads the input register, then the result register;
//   one request per cycle is taken unless out_ch.ready stalls the output.
// The per-console cursor and window update is one compare-and-add pass
//   between the two registers.
// Reset: synchronous, active low; cursors and windows return to each slice
//   origin, console 0 is current, attribute returns to 0x07.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_console_cursor_scroll_defines.svh"

module text_console_cursor_scroll import tccs_pkg::*; #(
  parameter int CONSOLES     = DEF_CONSOLES,
  parameter int ROW_CELLS    = DEF_ROW_CELLS,
  parameter int SCREEN_CELLS = DEF_SCREEN_CELLS,
  parameter int VMEM_WORDS   = DEF_VMEM_WORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tccs_req_if.sink              in_ch,
  tccs_res_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SLICE    = VMEM_WORDS / CONSOLES;
  localparam int LROW     = SLICE / ROW_CELLS;
  localparam int LREM     = SLICE % ROW_CELLS;
  localparam int LASTROW  = (SLICE - 1) / ROW_CELLS;
  localparam int LASTCOL  = (SLICE - 1) % ROW_CELLS;
  localparam int SCR_ROWS = SCREEN_CELLS / ROW_CELLS;
  localparam int SCR_REM  = SCREEN_CELLS % ROW_CELLS;
  localparam int MAXROW   = (SLICE > SCREEN_CELLS) ?
                            (SLICE - SCREEN_CELLS + ROW_CELLS - 1) / ROW_CELLS : 0;
  localparam int ROW_W    = $clog2(LROW + 1);
  localparam int COL_W    = $clog2(ROW_CELLS);
  localparam int SUM_W    = $clog2(LROW + SCR_ROWS + 2);
  localparam int CIDX_W   = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;

  // per-console state, offsets held as row and column within the slice
  logic [ROW_W-1:0]  crow_r [CONSOLES];
  logic [COL_W-1:0]  col_r  [CONSOLES];
  logic [ROW_W-1:0]  srow_r [CONSOLES];
  logic [CON_W-1:0]  cur_con_r;
  logic [CHAR_W-1:0] attr_r;

  logic s1_valid_r;
  req_t s1_r;
  logic out_valid_r;
  res_t res_r;

  logic adv;
  logic fire;
  logic c_ok;
  logic cfg_wr;

  logic [CIDX_W-1:0] cidx;
  logic [ROW_W-1:0]  crow, srow, crow_nxt, srow_nxt;
  logic [COL_W-1:0]  col, col_nxt;
  logic [ROW_W:0]    row_p1;
  logic [ADDR_W-1:0] origin, cur_addr, cur_addr_nxt;
  logic [SUM_W-1:0]  crow_ext, srow_lim, tgt;
  logic              over;
  logic [CON_W-1:0]  cur_con_nxt;
  res_t              res_nxt;

  // handshake
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || adv;
  assign fire         = s1_valid_r && adv && c_ok;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.vram_write     = res_r.vram_write;
  assign out_ch.vram_addr      = res_r.vram_addr;
  assign out_ch.vram_char      = res_r.vram_char;
  assign out_ch.vram_attr      = res_r.vram_attr;
  assign out_ch.display_update = res_r.display_update;
  assign out_ch.display_start  = res_r.display_start;
  assign out_ch.display_cursor = res_r.display_cursor;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[CFG_ADDR_W-1 -: CFG_IDX_W] == CFG_IDX_ATTR);
  assign prdata = (paddr[CFG_ADDR_W-1 -: CFG_IDX_W] == CFG_IDX_ATTR) ?
                  {{(CFG_DATA_W-CHAR_W){1'b0}}, attr_r} : '0;

  // state lookup
  assign c_ok     = ({1'b0, s1_r.console_index} < (CON_W+1)'(CONSOLES));
  assign cidx     = s1_r.console_index[CIDX_W-1:0];
  assign crow     = crow_r[cidx];
  assign col      = col_r[cidx];
  assign srow     = srow_r[cidx];
  assign origin   = ADDR_W'(SLICE) * ADDR_W'(cidx);
  assign cur_addr = origin + ADDR_W'(crow) * ADDR_W'(ROW_CELLS) + ADDR_W'(col);
  assign row_p1   = {1'b0, crow} + 1'b1;

  always_comb begin
    crow_nxt     = crow;
    col_nxt      = col;
    srow_nxt     = srow;
    cur_addr_nxt = cur_addr;
    cur_con_nxt  = cur_con_r;
    res_nxt      = '0;
    crow_ext     = '0;
    srow_lim     = '0;
    tgt          = '0;
    over         = 1'b0;

    case (req_type_t'(s1_r.req_type))
      REQ_CHAR: begin
        if (s1_r.char_code == CH_NEWLINE) begin
          if ((row_p1 < (ROW_W+1)'(LROW))
              || ((row_p1 == (ROW_W+1)'(LROW)) && (col < COL_W'(LREM)))) begin
            crow_nxt     = row_p1[ROW_W-1:0];
            col_nxt      = '0;
            cur_addr_nxt = cur_addr + ADDR_W'(ROW_CELLS) - ADDR_W'(col);
          end
        end else if (s1_r.char_code == CH_BACKSPACE) begin
          if ((crow != '0) || (col != '0)) begin
            if (col == '0) begin
              crow_nxt = crow - 1'b1;
              col_nxt  = COL_W'(ROW_CELLS - 1);
            end else begin
              col_nxt = col - 1'b1;
            end
            cur_addr_nxt       = cur_addr - 1'b1;
            res_nxt.vram_write = 1'b1;
            res_nxt.vram_addr  = cur_addr - 1'b1;
            res_nxt.vram_char  = CH_BLANK;
            res_nxt.vram_attr  = attr_r;
          end
        end else begin
          if (!((crow == ROW_W'(LASTROW)) && (col == COL_W'(LASTCOL)))) begin
            if (col == COL_W'(ROW_CELLS - 1)) begin
              crow_nxt = crow + 1'b1;
              col_nxt  = '0;
            end else begin
              col_nxt = col + 1'b1;
            end
            cur_addr_nxt       = cur_addr + 1'b1;
            res_nxt.vram_write = 1'b1;
            res_nxt.vram_addr  = cur_addr;
            res_nxt.vram_char  = s1_r.char_code;
            res_nxt.vram_attr  = attr_r;
          end
        end
        // pull the window down to the cursor, clamped at the slice end
        crow_ext = SUM_W'(crow_nxt);
        srow_lim = SUM_W'(srow) + SUM_W'(SCR_ROWS);
        over     = (crow_ext > srow_lim)
                   || ((crow_ext == srow_lim) && (col_nxt >= COL_W'(SCR_REM)));
        tgt      = crow_ext - SUM_W'(SCR_ROWS) + SUM_W'(col_nxt >= COL_W'(SCR_REM));
        if (over) begin
          srow_nxt = (tgt < SUM_W'(MAXROW)) ? tgt[ROW_W-1:0] : ROW_W'(MAXROW);
        end
      end
      REQ_SELECT: begin
        cur_con_nxt = s1_r.console_index;
      end
      REQ_SCROLL_UP: begin
        if (srow != '0) begin
          srow_nxt = srow - 1'b1;
        end
      end
      REQ_SCROLL_DOWN: begin
        if (srow < ROW_W'(MAXROW)) begin
          srow_nxt = srow + 1'b1;
        end
      end
      default: begin
        srow_nxt = srow;
      end
    endcase

    if (s1_r.console_index == cur_con_nxt) begin
      res_nxt.display_update = 1'b1;
      res_nxt.display_start  = origin + ADDR_W'(srow_nxt) * ADDR_W'(ROW_CELLS);
      res_nxt.display_cursor = cur_addr_nxt;
    end

    if (!c_ok) begin
      res_nxt = '0;
    end
  end

  // control and console state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cur_con_r   <= '0;
      attr_r      <= ATTR_RESET;
      for (int i = 0; i < CONSOLES; i++) begin
        crow_r[i] <= '0;
        col_r[i]  <= '0;
        srow_r[i] <= '0;
      end
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_wr) begin
        attr_r <= pwdata[CHAR_W-1:0];
      end
      if (fire) begin
        crow_r[cidx] <= crow_nxt;
        col_r[cidx]  <= col_nxt;
        srow_r[cidx] <= srow_nxt;
        cur_con_r    <= cur_con_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r.req_type      <= in_ch.req_type;
      s1_r.console_index <= in_ch.console_index;
      s1_r.char_code     <= in_ch.char_code;
    end
    if (adv && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  `TCCS_ASSERT_NEXT(a_stage_moves, s1_valid_r && adv, out_valid_r,
                    "accepted stage did not reach the result register")
  `TCCS_ASSERT_SAME(a_ready_when_free, !out_valid_r, in_ch.ready,
                    "input stalled with an empty result register")
  `TCCS_ASSERT_SAME(a_col_range, s1_valid_r && c_ok, col < COL_W'(ROW_CELLS),
                    "cursor column outside the row")
  `TCCS_ASSERT_SAME(a_window_clamp, s1_valid_r && c_ok, srow <= ROW_W'(MAXROW),
                    "display window beyond the slice end")

endmodule
